FILE: rtl/lz77d_pkg.sv
package lz77d_pkg;

  // Field widths of the symbol and byte channels, and of the size, count and window start.
  localparam int OFF_W    = 12;
  localparam int LEN_W    = 12;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int SIZE_W   = 24;
  localparam int CNT_W    = 25;
  localparam int WS_W     = 26;

  // The window start saturates here instead of wrapping.
  localparam int WS_MAX = 33554431;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_SKIP_BEFORE   = 3'd1,
    ST_SIZE_EXCEEDED = 3'd2,
    ST_TOO_LONG      = 3'd3,
    ST_IGNORED       = 3'd4
  } status_t;

  // Control of one cycle of the history ring.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic filled;   // every entry has been written since the last restart
  } ring_ctl_t;

endpackage

FILE: rtl/lz77d_if.sv
interface lz77d_sym_if;
  logic                           valid;
  logic                           ready;
  logic [lz77d_pkg::OFF_W-1:0]    copy_offset;
  logic [lz77d_pkg::LEN_W-1:0]    copy_length;
  logic [lz77d_pkg::BYTE_W-1:0]   literal_byte;
  logic                           last_symbol;

  modport source (output valid, copy_offset, copy_length, literal_byte, last_symbol,
                  input ready);
  modport sink (input valid, copy_offset, copy_length, literal_byte, last_symbol,
                output ready);
endinterface

interface lz77d_byte_if;
  logic                           valid;
  logic                           ready;
  logic [lz77d_pkg::BYTE_W-1:0]   data_byte;
  logic                           byte_valid;
  logic                           last_of_symbol;
  logic [lz77d_pkg::STATUS_W-1:0] status;

  modport source (output valid, data_byte, byte_valid, last_of_symbol, status,
                  input ready);
  modport sink (input valid, data_byte, byte_valid, last_of_symbol, status,
                output ready);
endinterface

FILE: rtl/lz77d_ring.sv
module lz77d_ring #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                         clk,
  input  lz77d_pkg::ring_ctl_t         ctl,
  input  logic [AW-1:0]                waddr,
  input  logic [lz77d_pkg::BYTE_W-1:0] wdata,
  input  logic [AW-1:0]                raddr,
  output logic [lz77d_pkg::BYTE_W-1:0] rdata
);

  logic [lz77d_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [lz77d_pkg::BYTE_W-1:0] rd_data_r;
  logic [lz77d_pkg::BYTE_W-1:0] last_wr_r;
  logic                         fwd_r;
  logic                         zero_r;

  // Writes fill the ring in order from entry zero, so the write address is also
  // the fill count: an entry at or past it holds stale data and reads as zero.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
      last_wr_r  <= wdata;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[raddr];
      fwd_r     <= ctl.wr_en && (raddr == waddr);
      zero_r    <= !ctl.filled && (raddr >= waddr);
    end
  end

  assign rdata = fwd_r  ? last_wr_r :
                 zero_r ? '0        : rd_data_r;

endmodule

FILE: rtl/lz77_symbol_decompressor.sv
// A symbol with no copy to make goes from IDLE to FINAL, which registers its closing item, or to
// IGNORE while stopped; a copy passes SMOD, which reduces the source to a ring index, then COPY
// and FINAL, and WMOD may then reduce the advanced window start. Copies move one byte per cycle
// while the output register is not stalled, through the single ring read port.
// Reset (rst_n low, synchronous) clears counters, window start and size; entries past the fill point read as zero.
module lz77_symbol_decompressor #(
  parameter int WINDOW_SIZE = 4096,
  parameter int MAX_COPY    = 63
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lz77d_sym_if.sink                    in_sym,
  lz77d_byte_if.source                 out_byte,
  input  logic                         cfg_we,
  input  logic [lz77d_pkg::SIZE_W-1:0] cfg_wdata
);

  // Ring address width, and the width of the sums that are reduced modulo the window.
  localparam int AW   = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int SUMW = ((AW > lz77d_pkg::OFF_W) ? AW : lz77d_pkg::OFF_W) + 1;
  localparam int RW   = (MAX_COPY > 1) ? $clog2(MAX_COPY + 1) : 1;
  localparam int WSM_SAT = lz77d_pkg::WS_MAX % WINDOW_SIZE;
  localparam logic [SUMW-1:0] W_SUM = SUMW'(WINDOW_SIZE);
  localparam logic [lz77d_pkg::WS_W-1:0] WS_INIT = lz77d_pkg::WS_W'(-WINDOW_SIZE);
  localparam logic signed [lz77d_pkg::WS_W:0] WS_SAT =
    (lz77d_pkg::WS_W + 1)'(lz77d_pkg::WS_MAX);

  // IDLE takes a symbol. SMOD reduces the copy source to a ring index and issues the
  // first read. COPY moves one byte per cycle while the output can take it. FINAL emits the closing
  // item, usually the literal. WMOD reduces the advanced window start. IGNORE answers a symbol while stopped.
  typedef enum logic [2:0] {
    S_IDLE, S_SMOD, S_COPY, S_FINAL, S_WMOD, S_IGNORE
  } state_t;

  state_t state_r, state_nxt;

  // Symbol being worked on.
  logic [lz77d_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [lz77d_pkg::BYTE_W-1:0] lit_r, lit_nxt;
  logic                         last_r, last_nxt;
  lz77d_pkg::status_t           status_r, status_nxt;

  // Sequencer working registers.
  logic [SUMW-1:0] red_r, red_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [RW-1:0]   rem_r, rem_nxt;

  // Stream state. The window start is tracked both as a signed value, for the
  // before-window check, and as its residue modulo the window, for ring addressing.
  logic [lz77d_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]                wp_r, wp_nxt;
  logic                         wrap_r, wrap_nxt;
  logic [lz77d_pkg::WS_W-1:0]   ws_r, ws_nxt;
  logic [AW-1:0]                wsm_r, wsm_nxt;
  logic                         stopped_r, stopped_nxt;
  logic [lz77d_pkg::SIZE_W-1:0] size_r;

  // Output register.
  logic                           out_valid_r, out_valid_nxt;
  logic [lz77d_pkg::BYTE_W-1:0]   out_data_r, out_data_nxt;
  logic                           out_bv_r, out_bv_nxt;
  logic                           out_last_r, out_last_nxt;
  lz77d_pkg::status_t             out_status_r, out_status_nxt;

  // Ring port.
  lz77d_pkg::ring_ctl_t         ring_ctl;
  logic [AW-1:0]                ring_raddr;
  logic [lz77d_pkg::BYTE_W-1:0] ring_wdata;
  logic [lz77d_pkg::BYTE_W-1:0] ring_rdata;

  logic                           adv;
  logic signed [lz77d_pkg::WS_W:0] src_sum;
  logic signed [lz77d_pkg::WS_W:0] ws_sum;
  logic                           over_size;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(WINDOW_SIZE - 1)) ? '0 : p + AW'(1);
  endfunction

  lz77d_ring #(
    .DEPTH (WINDOW_SIZE),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .ctl   (ring_ctl),
    .waddr (wp_r),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // A symbol is taken only between symbols; the output register decouples the
  // byte stream so the sequencer stalls only while an item waits in it undrained.
  assign in_sym.ready = (state_r == S_IDLE);

  // The output register can take a new item when empty or being drained.
  assign adv = !out_valid_r || out_byte.ready;

  assign src_sum = $signed({ws_r[lz77d_pkg::WS_W-1], ws_r}) +
                   $signed({{(lz77d_pkg::WS_W + 1 - lz77d_pkg::OFF_W){1'b0}},
                            in_sym.copy_offset});
  assign ws_sum  = $signed({ws_r[lz77d_pkg::WS_W-1], ws_r}) +
                   $signed({{(lz77d_pkg::WS_W + 1 - lz77d_pkg::LEN_W){1'b0}}, len_r}) +
                   $signed((lz77d_pkg::WS_W + 1)'(1));
  assign over_size = (cnt_r > {1'b0, size_r});

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    lit_nxt        = lit_r;
    last_nxt       = last_r;
    status_nxt     = status_r;
    red_nxt        = red_r;
    rd_ptr_nxt     = rd_ptr_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    wp_nxt         = wp_r;
    wrap_nxt       = wrap_r;
    ws_nxt         = ws_r;
    wsm_nxt        = wsm_r;
    stopped_nxt    = stopped_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_bv_nxt     = out_bv_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    ring_ctl.wr_en  = 1'b0;
    ring_ctl.rd_en  = 1'b0;
    ring_ctl.filled = wrap_r;
    ring_raddr      = red_r[AW-1:0];
    ring_wdata      = lit_r;

    if (out_valid_r && out_byte.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_sym.valid) begin
          len_nxt    = in_sym.copy_length;
          lit_nxt    = in_sym.literal_byte;
          last_nxt   = in_sym.last_symbol;
          status_nxt = lz77d_pkg::ST_OK;
          if (stopped_r) begin
            state_nxt = S_IGNORE;
          end else if (in_sym.copy_length == '0) begin
            state_nxt = S_FINAL;
          end else if (src_sum[lz77d_pkg::WS_W]) begin
            // The source lies before the start of the stream.
            status_nxt = lz77d_pkg::ST_SKIP_BEFORE;
            state_nxt  = S_FINAL;
          end else if (in_sym.copy_length > lz77d_pkg::LEN_W'(MAX_COPY)) begin
            status_nxt = lz77d_pkg::ST_TOO_LONG;
            state_nxt  = S_FINAL;
          end else begin
            red_nxt   = SUMW'(wsm_r) + SUMW'(in_sym.copy_offset);
            state_nxt = S_SMOD;
          end
        end
      end

      S_SMOD: begin
        if (red_r >= W_SUM) begin
          red_nxt = red_r - W_SUM;
        end else begin
          // First read of the copy; nothing is written in this cycle.
          ring_ctl.rd_en = 1'b1;
          ring_raddr     = red_r[AW-1:0];
          rd_ptr_nxt     = ptr_inc(red_r[AW-1:0]);
          rem_nxt        = RW'(len_r);
          state_nxt      = S_COPY;
        end
      end

      S_COPY: begin
        if (adv) begin
          // Emit and write back the byte read last, then read the next source byte.
          // The ring forwards the byte just written when the copy overlaps itself.
          out_valid_nxt  = 1'b1;
          out_data_nxt   = ring_rdata;
          out_bv_nxt     = 1'b1;
          out_last_nxt   = 1'b0;
          out_status_nxt = lz77d_pkg::ST_OK;
          ring_ctl.wr_en = 1'b1;
          ring_wdata     = ring_rdata;
          wp_nxt         = ptr_inc(wp_r);
          if (wp_r == AW'(WINDOW_SIZE - 1)) begin
            wrap_nxt = 1'b1;
          end
          cnt_nxt = cnt_r + lz77d_pkg::CNT_W'(1);
          rem_nxt = rem_r - RW'(1);
          if (rem_r != RW'(1)) begin
            ring_ctl.rd_en = 1'b1;
            ring_raddr     = rd_ptr_r;
            rd_ptr_nxt     = ptr_inc(rd_ptr_r);
          end else begin
            state_nxt = S_FINAL;
          end
        end
      end

      S_FINAL: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (over_size) begin
            // The stream ran past its declared size: stop until the last symbol.
            out_data_nxt   = '0;
            out_bv_nxt     = 1'b0;
            out_status_nxt = lz77d_pkg::ST_SIZE_EXCEEDED;
            stopped_nxt    = 1'b1;
          end else if ((cnt_r == {1'b0, size_r}) && (lit_r == '0)) begin
            // A trailing zero literal at the exact size is padding.
            out_data_nxt   = '0;
            out_bv_nxt     = 1'b0;
            out_status_nxt = status_r;
          end else begin
            out_data_nxt   = lit_r;
            out_bv_nxt     = 1'b1;
            out_status_nxt = status_r;
            ring_ctl.wr_en = 1'b1;
            ring_wdata     = lit_r;
            wp_nxt         = ptr_inc(wp_r);
            if (wp_r == AW'(WINDOW_SIZE - 1)) begin
              wrap_nxt = 1'b1;
            end
            cnt_nxt = cnt_r + lz77d_pkg::CNT_W'(1);
          end

          state_nxt = S_IDLE;
          if (!over_size) begin
            if (ws_sum > WS_SAT) begin
              ws_nxt  = lz77d_pkg::WS_W'(lz77d_pkg::WS_MAX);
              wsm_nxt = AW'(WSM_SAT);
            end else begin
              ws_nxt    = ws_sum[lz77d_pkg::WS_W-1:0];
              red_nxt   = SUMW'(wsm_r) + SUMW'(len_r) + SUMW'(1);
              state_nxt = S_WMOD;
            end
          end

          // The last symbol of a stream puts everything back to the start state.
          if (last_r) begin
            cnt_nxt     = '0;
            wp_nxt      = '0;
            wrap_nxt    = 1'b0;
            ws_nxt      = WS_INIT;
            wsm_nxt     = '0;
            stopped_nxt = 1'b0;
            state_nxt   = S_IDLE;
          end
        end
      end

      S_WMOD: begin
        if (red_r >= W_SUM) begin
          red_nxt = red_r - W_SUM;
        end else begin
          wsm_nxt   = red_r[AW-1:0];
          state_nxt = S_IDLE;
        end
      end

      S_IGNORE: begin
        if (adv) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '0;
          out_bv_nxt     = 1'b0;
          out_last_nxt   = 1'b1;
          out_status_nxt = lz77d_pkg::ST_IGNORED;
          state_nxt      = S_IDLE;
          if (last_r) begin
            cnt_nxt     = '0;
            wp_nxt      = '0;
            wrap_nxt    = 1'b0;
            ws_nxt      = WS_INIT;
            wsm_nxt     = '0;
            stopped_nxt = 1'b0;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    len_r        <= len_nxt;
    lit_r        <= lit_nxt;
    last_r       <= last_nxt;
    status_r     <= status_nxt;
    red_r        <= red_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    rem_r        <= rem_nxt;
    out_data_r   <= out_data_nxt;
    out_bv_r     <= out_bv_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      wp_r        <= '0;
      wrap_r      <= 1'b0;
      ws_r        <= WS_INIT;
      wsm_r       <= '0;
      stopped_r   <= 1'b0;
      size_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      wp_r        <= wp_nxt;
      wrap_r      <= wrap_nxt;
      ws_r        <= ws_nxt;
      wsm_r       <= wsm_nxt;
      stopped_r   <= stopped_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
    end
  end

  assign out_byte.valid          = out_valid_r;
  assign out_byte.data_byte      = out_data_r;
  assign out_byte.byte_valid     = out_bv_r;
  assign out_byte.last_of_symbol = out_last_r;
  assign out_byte.status         = out_status_r;

  // Every byte written to the ring is the byte presented on the output next cycle.
  a_ring_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    ring_ctl.wr_en |=> (out_valid_r && out_bv_r && (out_data_r == $past(ring_wdata))))
    else $error("ring write does not match the emitted byte");

  // The output count only ever steps by one, apart from a restart to zero.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ((cnt_r != $past(cnt_r)) && (cnt_r != '0)) |->
      (cnt_r == $past(cnt_r) + lz77d_pkg::CNT_W'(1)))
    else $error("output count jumped");

  // A stopped stream never copies.
  a_no_copy_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |-> !stopped_r)
    else $error("copy while stopped");

endmodule

FILE: tb/sv/tb_lz77_symbol_decompressor.sv
`timescale 1ns / 1ps

module tb_lz77_symbol_decompressor;

  // The block is built with its default window and copy bound; the predictor
  // below uses the same numbers.
  localparam int WIN         = 4096;
  localparam int COPY_MAX    = 63;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;
  localparam longint LIMIT   = 2000000;

  // One LZ77 symbol as it waits to be driven.
  typedef struct {
    logic [lz77d_pkg::OFF_W-1:0]  off;
    logic [lz77d_pkg::LEN_W-1:0]  len;
    logic [lz77d_pkg::BYTE_W-1:0] lit;
    logic                         last;
  } symbol_t;

  // One output item as the predictor works it out.
  typedef struct {
    logic [lz77d_pkg::BYTE_W-1:0] data;
    logic                         valid;
    logic                         last;
    lz77d_pkg::status_t           code;
  } byte_item_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [lz77d_pkg::SIZE_W-1:0] cfg_wdata;

  lz77d_sym_if  sym_if ();
  lz77d_byte_if byte_if ();

  lz77_symbol_decompressor #(
    .WINDOW_SIZE(WIN),
    .MAX_COPY   (COPY_MAX)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_sym   (sym_if),
    .out_byte (byte_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Symbols still to be driven, and output items the decoder owes us.
  symbol_t    symbol_queue[$];
  byte_item_t predicted_bytes[$];

  // Idling on both channels is enabled per phase. The long receiver hold-off is
  // armed by the stimulus process and counted down in a process of its own.
  bit idle_on;
  logic hold_arm = 1'b0;
  int hold_left = 0;
  int in_gap;
  int out_gap;

  // Run statistics for the closing summary.
  int     mismatches    = 0;
  int     symbols_sent  = 0;
  int     bytes_checked = 0;
  int     streams_ended = 0;
  int     size_settings = 0;
  longint cycles        = 0;

  // ---------------------------------------------------------------------------
  // Predictor state: history ring, output count, window start, stop flag and
  // the size register. This is our own model of the decoder.
  // ---------------------------------------------------------------------------
  logic [lz77d_pkg::BYTE_W-1:0] hist[WIN];
  int unsigned                  out_count;
  longint                       win_start;
  bit                           halted;
  logic [lz77d_pkg::SIZE_W-1:0] size_reg;

  // Window start as the stimulus generator tracks it, used to aim copies at
  // bytes that really exist. It only steers the stimulus, never the checks.
  longint gen_ws;

  function automatic void restart_stream();
    foreach (hist[i]) hist[i] = '0;
    out_count = 0;
    win_start = longint'(-WIN);
    halted    = 1'b0;
  endfunction

  function automatic void queue_result(logic [lz77d_pkg::BYTE_W-1:0] data, logic valid,
                                       logic last, lz77d_pkg::status_t code);
    byte_item_t r;
    r.data  = data;
    r.valid = valid;
    r.last  = last;
    r.code  = code;
    predicted_bytes.push_back(r);
  endfunction

  function automatic void store_byte(logic [lz77d_pkg::BYTE_W-1:0] b);
    hist[out_count % WIN] = b;
    out_count++;
  endfunction

  // Works out every output item that one accepted symbol causes and advances
  // the predictor state.
  function automatic void decode_symbol(logic [lz77d_pkg::OFF_W-1:0] off,
                                        logic [lz77d_pkg::LEN_W-1:0] len,
                                        logic [lz77d_pkg::BYTE_W-1:0] lit, logic last);
    longint                       src;
    lz77d_pkg::status_t           code;
    logic [lz77d_pkg::BYTE_W-1:0] b;
    int                           j;
    if (halted) begin
      // After a size overrun every symbol is dropped until the stream ends.
      queue_result('0, 1'b0, 1'b1, lz77d_pkg::ST_IGNORED);
    end else begin
      code = lz77d_pkg::ST_OK;
      if (len != 0) begin
        src = win_start + longint'(off);
        if (src < 0) begin
          code = lz77d_pkg::ST_SKIP_BEFORE;
        end else if (len > COPY_MAX) begin
          code = lz77d_pkg::ST_TOO_LONG;
        end else begin
          // Byte by byte, so a source close behind the output repeats bytes
          // written earlier in this same copy.
          for (j = 0; j < len; j++) begin
            b = hist[int'((src + j) % WIN)];
            store_byte(b);
            queue_result(b, 1'b1, 1'b0, lz77d_pkg::ST_OK);
          end
        end
      end
      if (out_count > size_reg) begin
        halted = 1'b1;
        queue_result('0, 1'b0, 1'b1, lz77d_pkg::ST_SIZE_EXCEEDED);
      end else if (out_count == size_reg && lit == '0) begin
        // A zero literal exactly at the stream size is padding and is dropped.
        queue_result('0, 1'b0, 1'b1, code);
      end else begin
        store_byte(lit);
        queue_result(lit, 1'b1, 1'b1, code);
      end
      if (!halted) begin
        win_start = win_start + longint'(len) + 1;
        if (win_start > lz77d_pkg::WS_MAX) win_start = longint'(lz77d_pkg::WS_MAX);
      end
    end
    if (last) restart_stream();
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic void queue_sym(int off, int len, int lit, bit last);
    symbol_t s;
    s.off  = lz77d_pkg::OFF_W'(off);
    s.len  = lz77d_pkg::LEN_W'(len);
    s.lit  = lz77d_pkg::BYTE_W'(lit);
    s.last = last;
    symbol_queue.push_back(s);
    gen_ws = last ? longint'(-WIN) : gen_ws + longint'(len) + 1;
  endfunction

  // Random streams, each closed by a last symbol. Most symbols are copies aimed
  // at bytes already written (offset WIN - d reads d bytes back while the window
  // start keeps pace with the output); the rest are plain literals, copies from
  // random places and copies over the length bound.
  task automatic queue_random_streams(int n);
    int     left;
    int     slen;
    int     k;
    int     pick;
    int     d;
    int     d_max;
    int     off;
    int     len;
    int     lit;
    longint reach;
    left = n;
    while (left > 0) begin
      slen = $urandom_range(1, 40);
      if (slen > left) slen = left;
      for (k = 0; k < slen; k++) begin
        pick  = $urandom_range(0, 99);
        lit   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 255);
        reach = gen_ws + WIN;
        if (pick < 60 && reach > 0) begin
          d_max = (reach < 300) ? int'(reach) : 300;
          if (reach >= WIN && $urandom_range(0, 7) == 0) d_max = WIN;
          d   = $urandom_range(1, d_max);
          off = WIN - d;
          len = $urandom_range(1, ($urandom_range(0, 3) == 0) ? COPY_MAX : 16);
        end else if (pick < 75) begin
          off = $urandom_range(0, WIN - 1);
          len = 0;
        end else if (pick < 88) begin
          off = $urandom_range(0, WIN - 1);
          len = $urandom_range(1, COPY_MAX);
        end else begin
          off = $urandom_range(0, WIN - 1);
          len = $urandom_range(COPY_MAX + 1, 4095);
        end
        queue_sym(off, len, lit, k == slen - 1);
      end
      left -= slen;
    end
  endtask

  // The size register is only written while the decoder is idle. The model
  // takes the new value at the same moment.
  task automatic write_size(logic [lz77d_pkg::SIZE_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_reg = v;
    size_settings++;
    @(negedge clk);
  endtask

  // Returns once every queued symbol has been taken and every predicted item
  // has come out. Sampled on the falling edge, away from the driving edge.
  task automatic wait_drained();
    do @(negedge clk);
    while (symbol_queue.size() != 0 || sym_if.valid || predicted_bytes.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Symbol driver. A symbol is held until it is accepted; between symbols the
  // sender may pause for a random burst. Each accepted symbol goes through the
  // predictor right at the accepting edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_symbols
    symbol_t s;
    if (!rst_n) begin
      sym_if.valid        <= 1'b0;
      sym_if.copy_offset  <= '0;
      sym_if.copy_length  <= '0;
      sym_if.literal_byte <= '0;
      sym_if.last_symbol  <= 1'b0;
      in_gap              <= 0;
      restart_stream();
    end else begin
      if (sym_if.valid && sym_if.ready) begin
        decode_symbol(sym_if.copy_offset, sym_if.copy_length, sym_if.literal_byte,
                      sym_if.last_symbol);
        symbols_sent++;
        if (sym_if.last_symbol) streams_ended++;
      end
      if (!sym_if.valid || sym_if.ready) begin
        if (in_gap != 0) begin
          in_gap       <= in_gap - 1;
          sym_if.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          in_gap       <= $urandom_range(0, 13);
          sym_if.valid <= 1'b0;
        end else if (symbol_queue.size() != 0) begin
          s = symbol_queue.pop_front();
          sym_if.copy_offset  <= s.off;
          sym_if.copy_length  <= s.len;
          sym_if.literal_byte <= s.lit;
          sym_if.last_symbol  <= s.last;
          sym_if.valid        <= 1'b1;
        end else begin
          sym_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so that the sender keeps offering
  // symbols while the output side is blocked.
  always @(posedge clk) begin
    if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Output ready with random stall bursts, forced low during the hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_if.ready <= 1'b0;
      out_gap       <= 0;
    end else if (out_gap != 0) begin
      out_gap       <= out_gap - 1;
      byte_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_gap       <= $urandom_range(0, 13);
      byte_if.ready <= 1'b0;
    end else begin
      byte_if.ready <= (hold_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: every accepted item is checked against the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_bytes
    byte_item_t e;
    if (rst_n && byte_if.valid && byte_if.ready) begin
      if (predicted_bytes.size() == 0) begin
        $error("unexpected output item: data_byte %0h byte_valid %0b status %0d",
               byte_if.data_byte, byte_if.byte_valid, byte_if.status);
        mismatches++;
      end else begin
        e = predicted_bytes.pop_front();
        bytes_checked++;
        if (byte_if.data_byte !== e.data) begin
          $error("data_byte: expected %0h, actual %0h", e.data, byte_if.data_byte);
          mismatches++;
        end
        if (byte_if.byte_valid !== e.valid) begin
          $error("byte_valid: expected %0b, actual %0b", e.valid, byte_if.byte_valid);
          mismatches++;
        end
        if (byte_if.last_of_symbol !== e.last) begin
          $error("last_of_symbol: expected %0b, actual %0b", e.last,
                 byte_if.last_of_symbol);
          mismatches++;
        end
        if (byte_if.status !== e.code) begin
          $error("status: expected %0d, actual %0d", e.code, byte_if.status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("tb_lz77_symbol_decompressor: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed streams first, then random streams under several
  // stream sizes.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_on   = 1'b1;
    gen_ws    = longint'(-WIN);
    size_reg  = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Unlimited size: copies of every kind.
    write_size(24'hFFFFFF);
    queue_sym(0, 0, 8'hFF, 0);          // plain literal, window start now -4095
    queue_sym(4095, 64, 8'hA5, 0);      // source 0, one byte over the copy bound
    queue_sym(4030, 63, 8'h3C, 0);      // longest copy, two bytes back, overlapping
    queue_sym(0, 4095, 8'h01, 0);       // source before the window, longest length
    queue_sym(0, 5, 8'h00, 0);          // source ahead of the output reads cleared ring
    queue_sym(0, 0, 8'h42, 1);          // end of stream, everything restarts
    queue_sym(0, 0, 8'h80, 0);
    queue_sym(4095, 40, 8'h7F, 0);      // one byte back: a run of the same byte
    queue_sym(4095, 1, 8'h00, 0);       // zero literal well below the size is kept
    queue_sym(0, 63, 8'h11, 1);         // skipped copy on the last symbol
    wait_drained();

    // Size zero: dropped zero literal, overrun after a copy, then ignored symbols.
    write_size('0);
    queue_sym(0, 0, 8'h00, 0);
    queue_sym(4095, 3, 8'h00, 0);
    queue_sym(123, 7, 8'h09, 0);
    queue_sym(4095, 4095, 8'hFF, 1);
    queue_sym(0, 0, 8'h5A, 0);
    queue_sym(0, 2, 8'h00, 0);          // overrun even though the copy was skipped
    queue_sym(0, 0, 8'h00, 1);
    wait_drained();

    // Size ten: reach the size exactly, drop padding, then overrun.
    write_size(24'd10);
    queue_sym(0, 0, 8'h11, 0);
    queue_sym(4095, 9, 8'h00, 0);       // count hits the size, zero literal dropped
    queue_sym(0, 5, 8'h00, 0);          // dropped again, this time with a skipped copy
    queue_sym(0, 0, 8'h22, 0);          // nonzero literal still goes out
    queue_sym(0, 0, 8'h33, 1);          // one past the size
    wait_drained();

    // Random streams with an unlimited size. The receiver holds off for a long
    // stretch at the start so the decoder backs up into its input.
    idle_on = 1'b1;
    write_size(24'hFFFFFF);
    queue_random_streams(50);
    @(posedge clk);
    hold_arm <= 1'b1;
    @(posedge clk);
    hold_arm <= 1'b0;
    wait_drained();

    // Moderate and tiny sizes, so that streams hit the size and stop.
    write_size(lz77d_pkg::SIZE_W'($urandom_range(200, 3000)));
    queue_random_streams(40);
    wait_drained();
    write_size(lz77d_pkg::SIZE_W'($urandom_range(1, 60)));
    queue_random_streams(40);
    wait_drained();

    // Last part runs at full rate on both sides.
    idle_on = 1'b0;
    write_size(lz77d_pkg::SIZE_W'($urandom_range(3000, 24'hFFFFFF)));
    queue_random_streams(50);
    wait_drained();

    // Give the decoder time to show any item that nobody asked for.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (predicted_bytes.size() != 0) begin
      $error("%0d predicted output items never arrived", predicted_bytes.size());
    end

    $display("Covered %0d symbols in %0d streams under %0d size settings, %s",
             symbols_sent, streams_ended, size_settings,
             "with overlapping copies, skipped copies, overruns and padding.");
    $display("Checked %0d output items field by field, %0d mismatches.",
             bytes_checked, mismatches);
    if (mismatches == 0 && predicted_bytes.size() == 0) begin
      $display("tb_lz77_symbol_decompressor: PASS");
    end else begin
      $display("tb_lz77_symbol_decompressor: FAIL");
    end
    $finish;
  end

endmodule

FILE: lz77_symbol_decompressor.f
rtl/lz77d_pkg.sv
rtl/lz77d_if.sv
rtl/lz77d_ring.sv
rtl/lz77_symbol_decompressor.sv
tb/sv/tb_lz77_symbol_decompressor.sv
